### sv/eilc_pkg.sv
// ----------------------------------------------------------------------------
// eilc_pkg
// Shared types and constants for the image layout checker.
// ----------------------------------------------------------------------------
package eilc_pkg;

  localparam int unsigned QDepth = 2;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_IDENT    = 4'd3,
    ST_TYPE     = 4'd4,
    ST_ENTSIZE  = 4'd5,
    ST_TABLE    = 4'd6,
    ST_FLAGS    = 4'd7,
    ST_BOUNDS   = 4'd8,
    ST_ADDRESS  = 4'd9,
    ST_LAYOUT   = 4'd10,
    ST_STACK    = 4'd11,
    ST_SEQUENCE = 4'd12
  } status_e;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_PAGE_SHIFT  = 2'd0,
    CFG_USER_BASE   = 2'd1,
    CFG_USER_LIMIT  = 2'd2,
    CFG_STACK_BYTES = 2'd3
  } cfg_e;

  localparam logic [31:0] MagicWord = 32'h464c_457f;
  localparam logic [15:0] MachineId = 16'hffb0;
  localparam logic [15:0] EntrySize = 16'd56;
  localparam logic [63:0] MinLength = 64'd64;
  localparam logic [31:0] SegLoad   = 32'd1;
  localparam logic [31:0] PermCode  = 32'd5;
  localparam logic [31:0] PermData  = 32'd6;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    op_e         op;
    logic [3:0]  hdr_status;   // header checks that need no state
    logic        is_load;
    logic        is_code;
    logic        flags_bad;
    logic [63:0] vaddr;
    logic [63:0] vend;         // vaddr + mem size
    logic        addr_bad;     // window check
    logic [63:0] length;       // image length field of the item
    logic [63:0] entry;
    logic [15:0] count;
    logic        fsz_gt_msz;
    logic [63:0] file_off;
    logic [63:0] file_size;
  } item_t;

endpackage

### sv/eilc_front.sv
// ----------------------------------------------------------------------------
// eilc_front
// Accepts items, does the stateless checks and registers the classified item.
// ----------------------------------------------------------------------------
module eilc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [63:0]          image_length_i,
  input  logic [63:0]          ident_word_i,
  input  logic [31:0]          type_machine_i,
  input  logic [63:0]          entry_point_i,
  input  logic [63:0]          table_offset_i,
  input  logic [31:0]          size_count_i,
  input  logic [63:0]          seg_type_flags_i,
  input  logic [63:0]          seg_file_offset_i,
  input  logic [63:0]          seg_vaddr_i,
  input  logic [63:0]          seg_file_size_i,
  input  logic [63:0]          seg_mem_size_i,
  input  logic [63:0]          user_base_i,
  input  logic [63:0]          user_limit_i,
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output eilc_pkg::item_t      item_o
);

  eilc_pkg::item_t item_d, item_q;
  logic            valid_q;
  logic [31:0]     flags;
  logic [64:0]     end_sum, tbl_bytes;
  logic [63:0]     room;
  logic [3:0]      hs;

  assign in_ready_o = !valid_q || item_ready_i;
  assign flags      = seg_type_flags_i[63:32];
  assign end_sum    = {1'b0, seg_vaddr_i} + {1'b0, seg_mem_size_i};
  assign room       = image_length_i - table_offset_i;
  assign tbl_bytes  = 65'(size_count_i[31:16]) * 65'(6'd56);

  always_comb begin
    if (image_length_i < eilc_pkg::MinLength) hs = eilc_pkg::ST_SHORT;
    else if (ident_word_i[31:0] != eilc_pkg::MagicWord) hs = eilc_pkg::ST_MAGIC;
    else if (ident_word_i[39:32] != 8'd2 || ident_word_i[47:40] != 8'd1 ||
             ident_word_i[55:48] != 8'd1) hs = eilc_pkg::ST_IDENT;
    else if (type_machine_i[15:0] != 16'd2 ||
             type_machine_i[31:16] != eilc_pkg::MachineId) hs = eilc_pkg::ST_TYPE;
    else if (size_count_i[15:0] != eilc_pkg::EntrySize) hs = eilc_pkg::ST_ENTSIZE;
    else if (table_offset_i > image_length_i || tbl_bytes > {1'b0, room})
      hs = eilc_pkg::ST_TABLE;
    else hs = eilc_pkg::ST_OK;
  end

  always_comb begin
    item_d            = item_q;
    item_d.op         = eilc_pkg::op_e'(op_i);
    item_d.hdr_status = hs;
    item_d.is_load    = seg_type_flags_i[31:0] == eilc_pkg::SegLoad;
    item_d.is_code    = flags == eilc_pkg::PermCode;
    item_d.flags_bad  = flags != eilc_pkg::PermCode && flags != eilc_pkg::PermData;
    item_d.vaddr      = seg_vaddr_i;
    item_d.vend       = end_sum[63:0];
    item_d.addr_bad   = seg_mem_size_i == '0 || seg_vaddr_i < user_base_i ||
                        end_sum[64] || end_sum[63:0] > user_limit_i;
    item_d.length     = image_length_i;
    item_d.entry      = entry_point_i;
    item_d.count      = size_count_i[31:16];
    item_d.fsz_gt_msz = seg_file_size_i > seg_mem_size_i;
    item_d.file_off   = seg_file_offset_i;
    item_d.file_size  = seg_file_size_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### sv/eilc_queue.sv
// ----------------------------------------------------------------------------
// eilc_queue
// Two-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module eilc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  eilc_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output eilc_pkg::item_t rd_item_o
);

  eilc_pkg::item_t mem_q [eilc_pkg::QDepth];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign wr_ready_o = cnt_q != 2'(eilc_pkg::QDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_item_i;
  end

endmodule

### sv/eilc_back.sv
// ----------------------------------------------------------------------------
// eilc_back
// Sequence state, range tracking, finish checks and the result register.
// ----------------------------------------------------------------------------
module eilc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  eilc_pkg::item_t item_i,
  input  logic [4:0]      page_shift_i,
  input  logic [63:0]     user_limit_i,
  input  logic [20:0]     stack_bytes_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [3:0]      status_o,
  output logic            done_res_o,
  output logic [63:0]     code_lo_o,
  output logic [63:0]     code_hi_o,
  output logic [63:0]     data_lo_o,
  output logic [63:0]     data_hi_o,
  output logic [63:0]     stack_lo_o,
  output logic [63:0]     stack_hi_o,
  output logic [63:0]     start_address_o
);

  logic        seen_q, seen_d;
  logic [3:0]  err_q, err_d;
  logic [63:0] len_q, len_d, ent_q, ent_d;
  logic [15:0] exp_q, exp_d, cnt_q, cnt_d;
  logic [63:0] clo_q, clo_d, chi_q, chi_d, dlo_q, dlo_d, dhi_q, dhi_d;
  logic        ov_q;
  logic [3:0]  st_d, st_q;
  logic        done_d, done_q;
  logic [63:0] slo_d, shi_d, slo_q, shi_q;
  logic [63:0] mask;
  logic [64:0] align_sum, hi_sum;
  logic        take;

  assign item_ready_o = !ov_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign mask         = (64'd1 << page_shift_i) - 64'd1;
  assign align_sum    = {1'b0, dhi_q} + {1'b0, mask};
  assign slo_d        = align_sum[63:0] & ~mask;
  assign hi_sum       = {1'b0, slo_d} + 65'(stack_bytes_i);
  assign shi_d        = hi_sum[63:0];

  always_comb begin
    seen_d = seen_q; err_d = err_q; len_d = len_q; ent_d = ent_q;
    exp_d = exp_q; cnt_d = cnt_q;
    clo_d = clo_q; chi_d = chi_q; dlo_d = dlo_q; dhi_d = dhi_q;
    st_d = eilc_pkg::ST_OK; done_d = 1'b0;
    if (err_q != eilc_pkg::ST_OK || item_i.op == eilc_pkg::OP_NONE) begin
      st_d = err_q;
    end else begin
      case (item_i.op)
        eilc_pkg::OP_HEADER: begin
          if (seen_q) st_d = eilc_pkg::ST_SEQUENCE;
          else begin
            st_d = item_i.hdr_status;
            if (item_i.hdr_status == eilc_pkg::ST_OK) begin
              len_d = item_i.length; ent_d = item_i.entry;
              exp_d = item_i.count; cnt_d = '0;
              clo_d = '0; chi_d = '0; dlo_d = '0; dhi_d = '0;
              seen_d = 1'b1;
            end
          end
        end
        eilc_pkg::OP_ENTRY: begin
          if (!seen_q || cnt_q >= exp_q) st_d = eilc_pkg::ST_SEQUENCE;
          else begin
            cnt_d = cnt_q + 16'd1;
            if (!item_i.is_load) st_d = eilc_pkg::ST_OK;
            else if (item_i.flags_bad) st_d = eilc_pkg::ST_FLAGS;
            else if (item_i.fsz_gt_msz || item_i.file_off > len_q ||
                     item_i.file_size > len_q - item_i.file_off)
              st_d = eilc_pkg::ST_BOUNDS;
            else if (item_i.addr_bad) st_d = eilc_pkg::ST_ADDRESS;
            else if (item_i.is_code) begin
              if (item_i.vaddr != '0 && (clo_q == '0 || item_i.vaddr < clo_q))
                clo_d = item_i.vaddr;
              if (item_i.vend > chi_q) chi_d = item_i.vend;
            end else begin
              if (item_i.vaddr != '0 && (dlo_q == '0 || item_i.vaddr < dlo_q))
                dlo_d = item_i.vaddr;
              if (item_i.vend > dhi_q) dhi_d = item_i.vend;
            end
          end
        end
        default: begin
          if (!seen_q || cnt_q != exp_q) st_d = eilc_pkg::ST_SEQUENCE;
          else if (clo_q == '0 || chi_q <= clo_q || dlo_q == '0 || dhi_q <= dlo_q ||
                   ent_q < clo_q || ent_q >= chi_q) st_d = eilc_pkg::ST_LAYOUT;
          else if (align_sum[64] || hi_sum[64] || shi_d > user_limit_i)
            st_d = eilc_pkg::ST_STACK;
          else begin
            done_d = 1'b1;
            seen_d = 1'b0;
          end
        end
      endcase
      if (st_d != eilc_pkg::ST_OK) begin
        err_d = st_d;
        cnt_d = cnt_q; clo_d = clo_q; chi_d = chi_q; dlo_d = dlo_q; dhi_d = dhi_q;
        if (item_i.op == eilc_pkg::OP_ENTRY && st_d != eilc_pkg::ST_SEQUENCE)
          cnt_d = cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0; err_q <= eilc_pkg::ST_OK;
      len_q <= '0; ent_q <= '0; exp_q <= '0; cnt_q <= '0;
      clo_q <= '0; chi_q <= '0; dlo_q <= '0; dhi_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (take) begin
        seen_d_apply: begin
          seen_q <= seen_d; err_q <= err_d; len_q <= len_d; ent_q <= ent_d;
          exp_q <= exp_d; cnt_q <= cnt_d;
          clo_q <= clo_d; chi_q <= chi_d; dlo_q <= dlo_d; dhi_q <= dhi_d;
        end
      end
      if (item_ready_o) ov_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_q   <= st_d;
      done_q <= done_d;
      slo_q  <= done_d ? slo_d : '0;
      shi_q  <= done_d ? shi_d : '0;
      code_lo_o       <= done_d ? clo_q : '0;
      code_hi_o       <= done_d ? chi_q : '0;
      data_lo_o       <= done_d ? dlo_q : '0;
      data_hi_o       <= done_d ? dhi_q : '0;
      start_address_o <= done_d ? ent_q : '0;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign done_res_o  = done_q;
  assign stack_lo_o  = slo_q;
  assign stack_hi_o  = shi_q;

endmodule

### sv/elf_image_layout_checker_top.sv
// ----------------------------------------------------------------------------
// elf_image_layout_checker_top
// Validates a 64-bit executable image header, program headers and layout.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | op_i, header and segment fields
// out     | output    | out_valid_o/out_ready_i | status_o ... start_address_o
// cfg     | input     | cfg_we_i             | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is held; the path runs through
// the front register, the queue and the result register. The back part updates
// sequence and range state for each item it takes. Reset clears the control
// state and loads the register defaults; data registers are not reset, no clearing
// pass. Either side may stall on its own: the two-entry queue absorbs the difference.
module elf_image_layout_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] image_length_i,
  input  logic [63:0] ident_word_i,
  input  logic [31:0] type_machine_i,
  input  logic [63:0] entry_point_i,
  input  logic [63:0] table_offset_i,
  input  logic [31:0] size_count_i,
  input  logic [63:0] seg_type_flags_i,
  input  logic [63:0] seg_file_offset_i,
  input  logic [63:0] seg_vaddr_i,
  input  logic [63:0] seg_file_size_i,
  input  logic [63:0] seg_mem_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic        done_res_o,
  output logic [63:0] code_lo_o,
  output logic [63:0] code_hi_o,
  output logic [63:0] data_lo_o,
  output logic [63:0] data_hi_o,
  output logic [63:0] stack_lo_o,
  output logic [63:0] stack_hi_o,
  output logic [63:0] start_address_o
);

  // Configuration registers
  logic [4:0]  page_shift_q;
  logic [63:0] user_base_q, user_limit_q;
  logic [20:0] stack_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= 5'd12;
      user_base_q   <= '0;
      user_limit_q  <= '1;
      stack_bytes_q <= 21'd8192;
    end else if (cfg_we_i) begin
      case (eilc_pkg::cfg_e'(cfg_index_i))
        eilc_pkg::CFG_PAGE_SHIFT:  page_shift_q  <= cfg_data_i[4:0];
        eilc_pkg::CFG_USER_BASE:   user_base_q   <= cfg_data_i;
        eilc_pkg::CFG_USER_LIMIT:  user_limit_q  <= cfg_data_i;
        eilc_pkg::CFG_STACK_BYTES: stack_bytes_q <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  eilc_pkg::item_t f_item, q_item;
  logic            f_valid, f_ready, q_valid, q_ready;

  eilc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .image_length_i,
    .ident_word_i, .type_machine_i, .entry_point_i, .table_offset_i,
    .size_count_i, .seg_type_flags_i, .seg_file_offset_i, .seg_vaddr_i,
    .seg_file_size_i, .seg_mem_size_i,
    .user_base_i  (user_base_q),
    .user_limit_i (user_limit_q),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  eilc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_item_i (f_item),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_item_o (q_item)
  );

  eilc_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i  (q_valid),
    .item_ready_o  (q_ready),
    .item_i        (q_item),
    .page_shift_i  (page_shift_q),
    .user_limit_i  (user_limit_q),
    .stack_bytes_i (stack_bytes_q),
    .out_valid_o, .out_ready_i, .status_o, .done_res_o, .code_lo_o, .code_hi_o,
    .data_lo_o, .data_hi_o, .stack_lo_o, .stack_hi_o, .start_address_o
  );

  // A finished result always reports a clean status.
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> status_o == eilc_pkg::ST_OK)
    else $error("done with nonzero status");

  // A non-finish result carries no ranges.
  a_zero_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> code_lo_o == '0 && stack_hi_o == '0)
    else $error("ranges on non-finish result");

  // Stalled output holds its status.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

endmodule

### bench/elf_image_layout_checker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elf_image_layout_checker_top_tb
// Self-checking bench: drives well-formed executable images with random
// content across several register settings, then one broken sequence and
// sticky-error noise; every result transfer is checked against a predictor.
// ----------------------------------------------------------------------------
module elf_image_layout_checker_top_tb;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] image_length;
    logic [63:0] ident_word;
    logic [31:0] type_machine;
    logic [63:0] entry_point;
    logic [63:0] table_offset;
    logic [31:0] size_count;
    logic [63:0] seg_type_flags;
    logic [63:0] seg_file_offset;
    logic [63:0] seg_vaddr;
    logic [63:0] seg_file_size;
    logic [63:0] seg_mem_size;
  } image_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        done_res;
    logic [63:0] code_lo;
    logic [63:0] code_hi;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic [63:0] stack_lo;
    logic [63:0] stack_hi;
    logic [63:0] start_address;
  } layout_result_t;

  // Predictor of the checker plus the queue of results still owed.
  class layout_scoreboard;
    logic [4:0]  page_shift = 5'd12;
    logic [63:0] user_base = '0;
    logic [63:0] user_limit = '1;
    logic [20:0] stack_bytes = 21'd8192;
    bit          header_open;
    logic [3:0]  sticky_err = eilc_pkg::ST_OK;
    logic [63:0] saved_len, saved_entry;
    logic [15:0] n_expected, n_seen;
    logic [63:0] code_lo, code_hi, data_lo, data_hi;
    layout_result_t owed_q[$];
    int          mismatches;

    function void set_reg(eilc_pkg::cfg_e idx, logic [63:0] v);
      case (idx)
        eilc_pkg::CFG_PAGE_SHIFT:  page_shift = v[4:0];
        eilc_pkg::CFG_USER_BASE:   user_base = v;
        eilc_pkg::CFG_USER_LIMIT:  user_limit = v;
        eilc_pkg::CFG_STACK_BYTES: stack_bytes = v[20:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] min_nz(logic [63:0] cur, logic [63:0] cand);
      if (cand == 0) return cur;
      if (cur == 0 || cand < cur) return cand;
      return cur;
    endfunction

    function logic [3:0] eval_header(image_item_t it);
      logic [15:0] cnt;
      logic [63:0] tbl_bytes;
      cnt = it.size_count[31:16];
      tbl_bytes = 64'd56 * cnt;
      if (it.image_length < eilc_pkg::MinLength) return eilc_pkg::ST_SHORT;
      if (it.ident_word[31:0] != eilc_pkg::MagicWord) return eilc_pkg::ST_MAGIC;
      if (it.ident_word[39:32] != 8'd2 || it.ident_word[47:40] != 8'd1 ||
          it.ident_word[55:48] != 8'd1) return eilc_pkg::ST_IDENT;
      if (it.type_machine[15:0] != 16'd2 ||
          it.type_machine[31:16] != eilc_pkg::MachineId)
        return eilc_pkg::ST_TYPE;
      if (it.size_count[15:0] != eilc_pkg::EntrySize) return eilc_pkg::ST_ENTSIZE;
      if (it.table_offset > it.image_length ||
          tbl_bytes > it.image_length - it.table_offset) return eilc_pkg::ST_TABLE;
      saved_len = it.image_length;
      saved_entry = it.entry_point;
      n_expected = cnt;
      n_seen = '0;
      code_lo = '0; code_hi = '0; data_lo = '0; data_hi = '0;
      header_open = 1;
      return eilc_pkg::ST_OK;
    endfunction

    function logic [3:0] eval_entry(image_item_t it);
      logic [31:0] flags;
      logic [63:0] vend;
      flags = it.seg_type_flags[63:32];
      if (!header_open || n_seen >= n_expected) return eilc_pkg::ST_SEQUENCE;
      n_seen = n_seen + 16'd1;
      if (it.seg_type_flags[31:0] != eilc_pkg::SegLoad) return eilc_pkg::ST_OK;
      if (flags != eilc_pkg::PermCode && flags != eilc_pkg::PermData)
        return eilc_pkg::ST_FLAGS;
      if (it.seg_file_size > it.seg_mem_size || it.seg_file_offset > saved_len ||
          it.seg_file_size > saved_len - it.seg_file_offset) return eilc_pkg::ST_BOUNDS;
      vend = it.seg_vaddr + it.seg_mem_size;
      if (it.seg_mem_size == 0 || it.seg_vaddr < user_base || vend < it.seg_vaddr ||
          vend > user_limit) return eilc_pkg::ST_ADDRESS;
      if (flags == eilc_pkg::PermCode) begin
        code_lo = min_nz(code_lo, it.seg_vaddr);
        if (vend > code_hi) code_hi = vend;
      end else begin
        data_lo = min_nz(data_lo, it.seg_vaddr);
        if (vend > data_hi) data_hi = vend;
      end
      return eilc_pkg::ST_OK;
    endfunction

    function logic [3:0] eval_finish(ref layout_result_t r);
      logic [63:0] mask, s_lo, s_hi;
      mask = (64'd1 << page_shift) - 64'd1;
      if (!header_open || n_seen != n_expected) return eilc_pkg::ST_SEQUENCE;
      if (code_lo == 0 || code_hi <= code_lo || data_lo == 0 || data_hi <= data_lo ||
          saved_entry < code_lo || saved_entry >= code_hi) return eilc_pkg::ST_LAYOUT;
      if (data_hi > ~mask) return eilc_pkg::ST_STACK;
      s_lo = (data_hi + mask) & ~mask;
      s_hi = s_lo + {43'd0, stack_bytes};
      if (s_hi < s_lo || s_hi > user_limit) return eilc_pkg::ST_STACK;
      r.done_res = 1'b1;
      r.code_lo = code_lo; r.code_hi = code_hi;
      r.data_lo = data_lo; r.data_hi = data_hi;
      r.stack_lo = s_lo; r.stack_hi = s_hi;
      r.start_address = saved_entry;
      header_open = 0;
      return eilc_pkg::ST_OK;
    endfunction

    function void note_input(image_item_t it);
      layout_result_t r;
      logic [3:0] st;
      r = '0;
      if (sticky_err != eilc_pkg::ST_OK || it.op == eilc_pkg::OP_NONE) begin
        r.status = sticky_err;
      end else begin
        case (it.op)
          eilc_pkg::OP_HEADER:
            st = header_open ? eilc_pkg::ST_SEQUENCE : eval_header(it);
          eilc_pkg::OP_ENTRY:  st = eval_entry(it);
          default:             st = eval_finish(r);
        endcase
        if (st != eilc_pkg::ST_OK) begin
          sticky_err = st;
          r = '0;
        end
        r.status = st;
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(layout_result_t act);
      layout_result_t exp;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", act);
        return;
      end
      exp = owed_q.pop_front();
      if (act.status !== exp.status || act.done_res !== exp.done_res ||
          act.code_lo !== exp.code_lo || act.code_hi !== exp.code_hi ||
          act.data_lo !== exp.data_lo || act.data_hi !== exp.data_hi ||
          act.stack_lo !== exp.stack_lo || act.stack_hi !== exp.stack_hi ||
          act.start_address !== exp.start_address) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch\n  exp %p\n  act %p", exp, act);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  op_i;
  logic [63:0] image_length_i, ident_word_i, entry_point_i, table_offset_i;
  logic [31:0] type_machine_i, size_count_i;
  logic [63:0] seg_type_flags_i, seg_file_offset_i, seg_vaddr_i;
  logic [63:0] seg_file_size_i, seg_mem_size_i;
  logic        out_valid_o, out_ready_i;
  logic [3:0]  status_o;
  logic        done_res_o;
  logic [63:0] code_lo_o, code_hi_o, data_lo_o, data_hi_o;
  logic [63:0] stack_lo_o, stack_hi_o, start_address_o;

  elf_image_layout_checker_top dut (.*);

  layout_scoreboard sb = new();

  // Shared knobs between stimulus and the receiver.
  bit no_idle;       // both sides: no random gaps
  bit hold_req;      // receiver: take one long hold-off
  int items_sent;

  // Current register values, used to build legal segments.
  logic [4:0]  cur_shift;
  logic [63:0] cur_base, cur_limit;
  logic [20:0] cur_stack;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit: far above the slowest legal run.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  // Ready changes at the clock edge; the transfer is sampled mid-cycle.
  initial begin
    int hold_left;
    layout_result_t r;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = 300;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 27);
      end
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        r = {status_o, done_res_o, code_lo_o, code_hi_o, data_lo_o, data_hi_o,
             stack_lo_o, stack_hi_o, start_address_o};
        sb.check_result(r);
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic image_item_t noise_item();
    image_item_t it;
    it = {2'($urandom), rnd64(), rnd64(), $urandom, rnd64(), rnd64(), $urandom,
          rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
    return it;
  endfunction

  // Offer one item; return at the edge where the transfer happened.
  task automatic send_item(image_item_t it);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {op_i, image_length_i, ident_word_i, type_machine_i, entry_point_i,
     table_offset_i, size_count_i, seg_type_flags_i, seg_file_offset_i,
     seg_vaddr_i, seg_file_size_i, seg_mem_size_i} <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(eilc_pkg::cfg_e idx, logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic load_setting(int which);
    case (which)
      0: begin
        cur_shift = 5'd12; cur_base = '0; cur_limit = '1; cur_stack = 21'd8192;
      end
      1: begin
        cur_shift = 5'd16; cur_base = 64'hffff_0000_0000_0000; cur_limit = '1;
        cur_stack = 21'd1048576;
      end
      2: begin
        cur_shift = 5'd13; cur_base = 64'h0000_1234_0000_0000;
        cur_limit = 64'h0000_1235_0000_0000; cur_stack = '0;
      end
      default: begin
        cur_shift = 5'd14; cur_base = 64'h8000_0000; cur_limit = 64'h1_8000_0000;
        cur_stack = 21'd4096;
      end
    endcase
    drain();
    write_reg(eilc_pkg::CFG_PAGE_SHIFT, {59'd0, cur_shift});
    write_reg(eilc_pkg::CFG_USER_BASE, cur_base);
    write_reg(eilc_pkg::CFG_USER_LIMIT, cur_limit);
    write_reg(eilc_pkg::CFG_STACK_BYTES, {43'd0, cur_stack});
  endtask

  function automatic image_item_t make_header(logic [15:0] cnt, logic [63:0] entry);
    image_item_t it;
    it = noise_item();
    it.op = eilc_pkg::OP_HEADER;
    it.image_length = rnd64() | 64'h10_0000;
    it.ident_word = {it.ident_word[63:56], 8'd1, 8'd1, 8'd2, eilc_pkg::MagicWord};
    it.type_machine = {eilc_pkg::MachineId, 16'd2};
    it.entry_point = entry;
    it.table_offset = {52'd0, it.table_offset[11:0]};
    it.size_count = {cnt, eilc_pkg::EntrySize};
    return it;
  endfunction

  function automatic image_item_t make_load(logic [31:0] perm, logic [63:0] va,
                                            logic [63:0] msz);
    image_item_t it;
    it = noise_item();
    it.op = eilc_pkg::OP_ENTRY;
    it.seg_type_flags = {perm, eilc_pkg::SegLoad};
    it.seg_vaddr = va;
    it.seg_mem_size = msz;
    it.seg_file_size = {32'd0, $urandom} % (msz + 64'd1);
    it.seg_file_offset = {52'd0, it.seg_file_offset[11:0]};
    return it;
  endfunction

  function automatic image_item_t make_skip();
    image_item_t it;
    it = noise_item();
    it.op = eilc_pkg::OP_ENTRY;
    if (it.seg_type_flags[31:0] == eilc_pkg::SegLoad) it.seg_type_flags[31:0] = 32'd0;
    return it;
  endfunction

  function automatic image_item_t make_finish();
    image_item_t it;
    it = noise_item();
    it.op = eilc_pkg::OP_FINISH;
    return it;
  endfunction

  // One legal image: a primary code and data segment in random slots, the rest
  // either skipped types or extra loads inside the same windows.
  task automatic run_image(bit zero_seg);
    int n, cpos, dpos;
    logic [63:0] cva, csz, dva, dsz, entry;
    n = $urandom_range(2, 6);
    cpos = $urandom_range(0, n - 1);
    do dpos = $urandom_range(0, n - 1); while (dpos == cpos);
    cva = cur_base + 64'h1000 + {40'd0, $urandom_range(0, 32'hff_ffff)};
    csz = {48'd0, 16'($urandom_range(1, 16'hffff))};
    dva = cur_base + 64'h1000_0000 + {40'd0, $urandom_range(0, 32'hff_ffff)};
    dsz = {48'd0, 16'($urandom_range(1, 16'hffff))};
    entry = cva + ({32'd0, $urandom} % csz);
    send_item(make_header(n[15:0] + zero_seg, entry));
    // Segment at address zero: must not pull the code range low.
    if (zero_seg) send_item(make_load(eilc_pkg::PermCode, '0, 64'h100));
    for (int i = 0; i < n; i++) begin
      if (i == cpos) send_item(make_load(eilc_pkg::PermCode, cva, csz));
      else if (i == dpos) send_item(make_load(eilc_pkg::PermData, dva, dsz));
      else if ($urandom_range(99) < 60) send_item(make_skip());
      else if ($urandom_range(1) == 0)
        send_item(make_load(eilc_pkg::PermCode, cva + {48'd0, 16'($urandom)},
                            64'd1 + $urandom_range(0, 4095)));
      else
        send_item(make_load(eilc_pkg::PermData, dva + {48'd0, 16'($urandom)},
                            64'd1 + $urandom_range(0, 4095)));
    end
    send_item(make_finish());
  endtask

  // One broken sequence; the error it raises sticks for the rest of the run.
  task automatic run_broken();
    image_item_t h, e;
    int kind;
    kind = $urandom_range(0, 11);
    h = make_header(16'd1, cur_base + 64'h2000);
    e = make_load(eilc_pkg::PermCode, cur_base + 64'h1000, 64'h2000);
    case (kind)
      0: h.image_length = 64'($urandom_range(0, 63));
      1: h.ident_word[7:0] = 8'h00;
      2: h.ident_word[47:40] = 8'd2;
      3: h.type_machine[31:16] = 16'h0003;
      4: h.size_count[15:0] = 16'd64;
      5: h.table_offset = h.image_length + 64'd1;
      6: h = make_skip();
      7: e.seg_type_flags[63:32] = 32'd7;
      8: begin e.seg_file_size = 64'h10; e.seg_mem_size = 64'h8; end
      9: e.seg_mem_size = '0;
      10: e = make_skip();
      // Stack overflow: data ends at the very top, so aligning carries out.
      11: h = make_header(16'd2, cur_base + 64'h2000);
      default: ;
    endcase
    send_item(h);
    send_item(e);
    if (kind == 11)
      send_item(make_load(eilc_pkg::PermData, 64'hffff_ffff_ffff_ff00, 64'hff));
    send_item(make_finish());
  endtask

  initial begin
    cfg_we_i = 1'b0; cfg_index_i = eilc_pkg::CFG_PAGE_SHIFT; cfg_data_i = '0;
    in_valid_i = 1'b0;
    {op_i, image_length_i, ident_word_i, type_machine_i, entry_point_i,
     table_offset_i, size_count_i, seg_type_flags_i, seg_file_offset_i,
     seg_vaddr_i, seg_file_size_i, seg_mem_size_i} = '0;
    no_idle = 0; hold_req = 0; items_sent = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: default setting, zero-address segment, ignored op three.
    load_setting(0);
    run_image(1);
    send_item(noise_item() | {eilc_pkg::OP_NONE, 640'd0});
    run_image(0);
    load_setting(1);
    run_image(0);

    // Random: legal images across settings, with one long receiver hold-off
    // and one burst where neither side idles.
    hold_req = 1;
    while (items_sent < 560) begin
      if ($urandom_range(7) == 0) load_setting($urandom_range(0, 3));
      no_idle = (items_sent >= 200 && items_sent < 300);
      run_image($urandom_range(9) == 0 && cur_base == 0);
    end
    no_idle = 0;

    // Broken sequence, then noise on top of the sticky error.
    load_setting(0);
    run_broken();
    repeat (20) send_item(noise_item());

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
sv/eilc_pkg.sv
sv/eilc_front.sv
sv/eilc_queue.sv
sv/eilc_back.sv
sv/elf_image_layout_checker_top.sv
bench/elf_image_layout_checker_top_tb.sv
